// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes, field widths and the control bundle shared by the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned OP_WIDTH    = 2;
    localparam int unsigned KEY_BITS    = 32;
    localparam int unsigned COUNT_BITS  = 5;
    localparam int unsigned WIDE_BITS   = 64;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

// File: rtl/spq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Operation channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface spq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::OP_WIDTH-1:0]        op;
    logic signed [spq_pkg::KEY_BITS-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink (input valid, input op, input key, output ready);
endinterface : spq_cmd_if

interface spq_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [spq_pkg::KEY_BITS-1:0] top_key;
    logic                                queue_empty;
    logic [spq_pkg::COUNT_BITS-1:0]      entry_count;
    logic                                push_refused;

    modport source (output valid, output top_key, output queue_empty,
                    output entry_count, output push_refused, input ready);
    modport sink (input valid, input top_key, input queue_empty,
                  input entry_count, input push_refused, output ready);
endinterface : spq_res_if
`default_nettype wire

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one key of the descending list and trades keys with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire spq_pkg::cell_ctrl_t         ctrl,
    input  wire logic                        occupied,
    input  wire logic signed [KEY_WIDTH-1:0] new_key,
    input  wire logic signed [KEY_WIDTH-1:0] left_key,
    input  wire logic                        left_shift,
    input  wire logic signed [KEY_WIDTH-1:0] right_key,
    output logic signed [KEY_WIDTH-1:0]      key,
    output logic                             shift
);

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;

    // A cell moves right on a push when it is empty or the new key is not below its own key.
    assign shift = !occupied || (new_key >= key_reg);
    assign key   = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.push && shift)
        begin
            key_next = left_shift ? left_key : new_key;
        end
        else if (ctrl.pop)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule : spq_cell
`default_nettype wire

// File: rtl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded max-first queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The cmd channel carries one operation per transaction: push a key, pop
// the largest key, or clear the queue. Every accepted transaction produces
// exactly one transaction on the res channel that reports the queue after
// the operation: the largest key (zero when empty), the empty flag, the
// number of stored keys and a flag for a push dropped on a full queue.
// All cells compare the incoming key with their own key in parallel and
// shift by one place in the same cycle, so an operation completes in the
// cycle it is accepted and its result is presented on the following
// cycle. The result register is a single stage: a new operation is taken
// in the cycle its predecessor's result leaves, so the block sustains one
// transaction per cycle while the receiver keeps ready high. When the
// receiver stalls, the result holds and cmd.ready stays low until it is
// taken. Reset empties the queue and drops any pending result; stored keys
// need no clearing because only entries below the count are ever reported.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_cmd_if.sink    cmd,
    spq_res_if.source  res
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        refused_reg;
    logic                        refused_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        accept;
    logic                        full;
    spq_pkg::op_t                op;
    spq_pkg::cell_ctrl_t         ctrl;
    logic signed [spq_pkg::WIDE_BITS-1:0] key_wide;
    logic signed [KEY_WIDTH-1:0] new_key;
    logic signed [spq_pkg::WIDE_BITS-1:0] head_wide;
    logic [CW+spq_pkg::COUNT_BITS-1:0]    count_ext;

    logic signed [KEY_WIDTH-1:0] cell_key   [CAPACITY];
    logic                        cell_shift [CAPACITY];
    logic                        occupied   [CAPACITY];

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !out_valid_reg || res.ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign op        = spq_pkg::op_t'(cmd.op);
    assign key_wide  = spq_pkg::WIDE_BITS'(cmd.key);
    assign new_key   = key_wide[KEY_WIDTH-1:0];

    always_comb
    begin
        ctrl.push = 1'b0;
        ctrl.pop  = 1'b0;
        if (accept)
        begin
            case (op)
                spq_pkg::OP_PUSH: ctrl.push = !full;
                spq_pkg::OP_POP:  ctrl.pop  = (count_reg != '0);
                default:          ctrl      = '0;
            endcase
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        refused_next = refused_reg;
        if (accept)
        begin
            refused_next = 1'b0;
            case (op)
                spq_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                spq_pkg::OP_POP:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                spq_pkg::OP_CLEAR: count_next = '0;
                default:           count_next = count_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            refused_reg   <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            refused_reg   <= refused_next;
            count_reg     <= count_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign occupied[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            spq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .new_key    (new_key),
                .left_key   (new_key),
                .left_shift (1'b0),
                .right_key  (cell_key[(i + 1) % CAPACITY]),
                .key        (cell_key[i]),
                .shift      (cell_shift[i])
            );
        end
        else if (i == CAPACITY - 1)
        begin : g_last
            spq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .new_key    (new_key),
                .left_key   (cell_key[i - 1]),
                .left_shift (cell_shift[i - 1]),
                .right_key  (cell_key[i]),
                .key        (cell_key[i]),
                .shift      (cell_shift[i])
            );
        end
        else
        begin : g_mid
            spq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .new_key    (new_key),
                .left_key   (cell_key[i - 1]),
                .left_shift (cell_shift[i - 1]),
                .right_key  (cell_key[i + 1]),
                .key        (cell_key[i]),
                .shift      (cell_shift[i])
            );
        end
    end

    assign head_wide = spq_pkg::WIDE_BITS'(cell_key[0]);
    assign count_ext = {{spq_pkg::COUNT_BITS{1'b0}}, count_reg};

    assign res.valid        = out_valid_reg;
    assign res.top_key      = (count_reg != '0) ? head_wide[spq_pkg::KEY_BITS-1:0] : '0;
    assign res.queue_empty  = (count_reg == '0);
    assign res.entry_count  = count_ext[spq_pkg::COUNT_BITS-1:0];
    assign res.push_refused = refused_reg;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_refused_full : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && refused_reg) |-> full)
        else $error("push refused while the queue has room");

    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == spq_pkg::OP_POP && count_reg != '0)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not remove exactly one key");

    a_head_order : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (cell_key[0] >= cell_key[1]))
        else $error("head key ranks below the second key");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(count_reg)))
        else $error("queue changed while a result was stalled");
`endif

endmodule : sorted_priority_queue_top
`default_nettype wire
